// File: rtl/wigner_3j_symbol_defines.svh
// Assertion macros for the Wigner 3j block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef WIGNER_3J_SYMBOL_DEFINES_SVH
`define WIGNER_3J_SYMBOL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define W3J_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define W3J_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define W3J_ASSERT(lbl, clk, rstn, prop, msg)
`define W3J_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/w3j_pkg.sv
// Package for the Wigner 3j block: FP opcodes, factorial table and helpers.
// No dependencies.
`timescale 1ns / 1ps
package w3j_pkg;
  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_DIV = 3'd1,
    OP_ADD = 3'd2,
    OP_SQRT = 3'd3,
    OP_PASS = 3'd4
  } fop_e;

  typedef struct packed {
    logic start;
    fop_e op;
  } fcmd_t;

  localparam int unsigned FactMax = 61;

  // exact double factorials while representable; later entries computed by rounding
  // products in rising order, done at elaboration by the function below
  function automatic logic [63:0] fact_bits(input logic [5:0] n);
    real r;
    r = 1.0;
    for (int i = 2; i <= int'(FactMax); i++) begin
      if (i <= int'(n)) begin
        r = r * real'(i);
      end
    end
    return $realtobits(r);
  endfunction
endpackage

// File: rtl/wigner_3j_symbol.sv
// Wigner 3j symbol by the Racah formula for integer momenta, result as a double bit
// pattern. One transaction is taken, then s_axis_tready stays low until the result
// transaction has gone out. All arithmetic runs on one shared iterative double unit.
// A Racah term is six multiplies, a divide and an add; there are up to LMAX+1 terms,
// then nine multiplies, a divide, the root and the phase multiply. A rejected item
// gives its zero result the cycle after it is accepted.
// Depends on w3j_pkg, w3j_fpu and wigner_3j_symbol_defines.svh.
`timescale 1ns / 1ps
`include "wigner_3j_symbol_defines.svh"
module wigner_3j_symbol #(
  parameter int unsigned LMAX = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // j_first[3:0], m_first[8:4], j_second[12:9], m_second[17:13], j_third[21:18],
  // m_third[26:22], zero fill to 32
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // symbol_value[63:0]
  output logic [63:0] m_axis_tdata
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TERM = 5'b00010,
    ST_ARG  = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic signed [6:0] j1, j2, j3, m1, m2, m3;
  logic signed [6:0] j1_q, j2_q, j3_q, m1_q, m2_q, m3_q;
  logic signed [6:0] t_q, t_d, hi_q, hi_d, lo;
  logic signed [6:0] t1, t2, t3, t4, t5;
  logic [3:0] step_q, step_d;
  logic [63:0] sum_q, sum_d, acc_q, acc_d, out_q, out_d;
  logic [63:0] fa, fb;
  logic signed [6:0] fidx;
  w3j_pkg::fcmd_t cmd;
  logic fdone;
  logic [63:0] fres;
  logic issued_q, issued_d;
  logic ok;

  function automatic logic [63:0] fact_lut(input logic signed [6:0] n);
    logic [63:0] v;
    v = 64'h3FF0000000000000;
    for (int k = 0; k <= int'(w3j_pkg::FactMax); k++) begin
      if (int'(n) == k) v = w3j_pkg::fact_bits(6'(k));
    end
    return v;
  endfunction

  assign j1 = $signed({3'b000, s_axis_tdata[3:0]});
  assign m1 = $signed({{2{s_axis_tdata[8]}}, s_axis_tdata[8:4]});
  assign j2 = $signed({3'b000, s_axis_tdata[12:9]});
  assign m2 = $signed({{2{s_axis_tdata[17]}}, s_axis_tdata[17:13]});
  assign j3 = $signed({3'b000, s_axis_tdata[21:18]});
  assign m3 = $signed({{2{s_axis_tdata[26]}}, s_axis_tdata[26:22]});

  assign t1 = j2_q - m1_q - j3_q;
  assign t2 = j1_q + m2_q - j3_q;
  assign t3 = j1_q + j2_q - j3_q;
  assign t4 = j1_q - m1_q;
  assign t5 = j2_q + m2_q;

  always_comb begin
    ok = (j1 <= 7'(LMAX)) && (j2 <= 7'(LMAX)) && (j3 <= 7'(LMAX));
    ok = ok && (j3 <= j1 + j2) && (j3 >= ((j1 > j2) ? j1 - j2 : j2 - j1));
    ok = ok && (((m1 < 0) ? -m1 : m1) <= j1) && (((m2 < 0) ? -m2 : m2) <= j2);
    ok = ok && (((m3 < 0) ? -m3 : m3) <= j3) && (m1 + m2 + m3 == 7'sd0);
    lo = 7'sd0;
    if (t1 > lo) lo = t1;
    if (t2 > lo) lo = t2;
  end

  // per-term steps: six multiplies, divide into +-1, add;
  // argument: 3 mul, 1 div, 6 mul, sqrt, phase
  always_comb begin
    fidx = 7'sd0;
    unique case (step_q)
      4'd1: fidx = t_q;
      4'd2: fidx = t_q - t1;
      4'd3: fidx = t_q - t2;
      4'd4: fidx = t3 - t_q;
      4'd5: fidx = t4 - t_q;
      4'd6: fidx = t5 - t_q;
      default: fidx = 7'sd0;
    endcase
    if (state_q == ST_ARG) begin
      unique case (step_q)
        4'd0: fidx = t3;
        4'd1: fidx = j1_q - j2_q + j3_q;
        4'd2: fidx = -j1_q + j2_q + j3_q;
        4'd3: fidx = j1_q + j2_q + j3_q + 7'sd1;
        4'd4: fidx = j1_q + m1_q;
        4'd5: fidx = j1_q - m1_q;
        4'd6: fidx = j2_q + m2_q;
        4'd7: fidx = j2_q - m2_q;
        4'd8: fidx = j3_q + m3_q;
        4'd9: fidx = j3_q - m3_q;
        default: fidx = 7'sd0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q; t_d = t_q; hi_d = hi_q; step_d = step_q;
    sum_d = sum_q; acc_d = acc_q; out_d = out_q; issued_d = issued_q;
    cmd.start = 1'b0; cmd.op = w3j_pkg::OP_PASS; fa = acc_q; fb = fact_lut(fidx);
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (ok) begin
            state_d = ST_WAIT;
            step_d = 4'd0;
            sum_d = 64'd0;
          end else begin
            out_d = 64'd0;
            state_d = ST_OUT;
          end
        end
      end
      ST_WAIT: begin
        // derive range once operands settle
        t_d = lo;
        hi_d = t3;
        if (t4 < hi_d) hi_d = t4;
        if (t5 < hi_d) hi_d = t5;
        acc_d = 64'h3FF0000000000000;
        step_d = 4'd1;
        state_d = (t_d > hi_d) ? ST_ARG : ST_TERM;
        if (t_d > hi_d) step_d = 4'd0;
      end
      ST_TERM: begin
        if (!issued_q) begin
          cmd.start = 1'b1;
          cmd.op = w3j_pkg::OP_MUL;
          if (step_q == 4'd7) begin
            cmd.op = w3j_pkg::OP_DIV;
            fa = t_q[0] ? 64'hBFF0000000000000 : 64'h3FF0000000000000;
            fb = acc_q;
          end
          if (step_q == 4'd8) begin
            cmd.op = w3j_pkg::OP_ADD;
            fb = sum_q;
          end
          issued_d = 1'b1;
        end else if (fdone) begin
          issued_d = 1'b0;
          if (step_q == 4'd8) begin
            sum_d = fres;
            acc_d = 64'h3FF0000000000000;
            if (t_q == hi_q) begin
              state_d = ST_ARG; step_d = 4'd0;
            end else begin
              t_d = t_q + 7'sd1;
              step_d = 4'd1;
            end
          end else begin
            acc_d = fres; step_d = step_q + 4'd1;
          end
        end
      end
      ST_ARG: begin
        if (!issued_q) begin
          cmd.start = 1'b1;
          cmd.op = (step_q == 4'd3) ? w3j_pkg::OP_DIV : w3j_pkg::OP_MUL;
          if (step_q == 4'd10) cmd.op = w3j_pkg::OP_SQRT;
          if (step_q == 4'd11) begin
            fb = {sum_q[63] ^ (j1_q[0] ^ j2_q[0] ^ m3_q[0]), sum_q[62:0]};
          end
          issued_d = 1'b1;
        end else if (fdone) begin
          issued_d = 1'b0;
          acc_d = fres;
          step_d = step_q + 4'd1;
          if (step_q == 4'd11) begin
            out_d = fres; state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  w3j_fpu u_fpu (
    .clk_i (clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .a_i(fa), .b_i(fb),
    .done_o(fdone), .res_o(fres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; step_q <= 4'd0; issued_q <= 1'b0;
    end else begin
      state_q <= state_d; step_q <= step_d; issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      j1_q <= j1; j2_q <= j2; j3_q <= j3; m1_q <= m1; m2_q <= m2; m3_q <= m3;
    end
    t_q <= t_d; hi_q <= hi_d; sum_q <= sum_d; acc_q <= acc_d; out_q <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = out_q;

  `W3J_ASSERT(a_excl, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "ready while holding")
  `W3J_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "out moved")
  `W3J_ASSERT(a_noiss, clk_i, rst_ni, cmd.start |-> !issued_q, "double issue")
  `W3J_ASSERT(a_done, clk_i, rst_ni, fdone |-> issued_q, "stray done")
endmodule

// File: rtl/w3j_fpu.sv
// Shared iterative double unit: multiply, divide, add, square root.
// Depends on w3j_pkg. Round to nearest even on normal operands only.
`timescale 1ns / 1ps
module w3j_fpu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  w3j_pkg::fcmd_t   cmd_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  w3j_pkg::fop_e op_q, op_d;
  logic        sgn_q, sgn_d;
  logic signed [12:0] exp_q, exp_d;
  logic [108:0] acc_q, acc_d;
  logic [108:0] rem_q, rem_d;
  logic [55:0]  quo_q, quo_d;
  logic [52:0]  mb_q, mb_d;
  logic [63:0]  res_q, res_d;
  logic         done_q, done_d;
  logic         rnd_q, rnd_d;

  logic [52:0] ma, mb;
  logic signed [12:0] ea, eb;
  logic [11:0] ed;
  logic [55:0] sh;
  logic [56:0] sum;
  logic [108:0] trial;
  logic [54:0] r;
  logic        stick, lsb, rb;

  assign ma = {(a_i[62:52] != 11'd0), a_i[51:0]};
  assign mb = {(b_i[62:52] != 11'd0), b_i[51:0]};
  assign ea = $signed({2'b00, a_i[62:52]});
  assign eb = $signed({2'b00, b_i[62:52]});

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; op_d = op_q; sgn_d = sgn_q; exp_d = exp_q;
    acc_d = acc_q; rem_d = rem_q; quo_d = quo_q; mb_d = mb_q; res_d = res_q;
    done_d = 1'b0; rnd_d = rnd_q;
    ed = 12'd0; sh = 56'd0; sum = 57'd0; trial = 109'd0;
    r = 55'd0; stick = 1'b0; lsb = 1'b0; rb = 1'b0;
    if (cmd_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d = cmd_i.op;
      cnt_d = 7'd0;
      mb_d = mb;
      rem_d = 109'd0;
      quo_d = 56'd0;
      unique case (cmd_i.op)
        w3j_pkg::OP_MUL: begin
          sgn_d = a_i[63] ^ b_i[63];
          exp_d = ea + eb - 13'sd1023;
          acc_d = {56'd0, ma};
          if (a_i[62:0] == 63'd0 || b_i[62:0] == 63'd0) begin
            op_d = w3j_pkg::OP_PASS;
            res_d = {a_i[63] ^ b_i[63], 63'd0};
          end
        end
        w3j_pkg::OP_DIV: begin
          sgn_d = a_i[63] ^ b_i[63];
          exp_d = ea - eb + 13'sd1023;
          rem_d = {56'd0, ma};
        end
        w3j_pkg::OP_ADD: begin
          // operands are positive or negative normals with |a|>=|b| not assumed
          if (a_i[62:0] == 63'd0) begin
            op_d = w3j_pkg::OP_PASS; res_d = b_i;
            if (b_i[62:0] == 63'd0) res_d = {a_i[63] & b_i[63], 63'd0};
          end else if (b_i[62:0] == 63'd0) begin
            op_d = w3j_pkg::OP_PASS; res_d = a_i;
          end else begin
            if (a_i[62:0] >= b_i[62:0]) begin
              ed = {1'b0, a_i[62:52]} - {1'b0, b_i[62:52]};
              sh = (ed > 12'd55) ? {55'd0, 1'b1} : {mb, 3'b000} >> ed;
              if (ed > 12'd2 && ed <= 12'd55) begin
                sh[0] = sh[0] | (({mb, 3'b000} & ((56'd1 << ed) - 56'd1)) != 56'd0);
              end
              sgn_d = a_i[63];
              exp_d = ea;
              sum = (a_i[63] == b_i[63]) ? {1'b0, ma, 3'b000} + {1'b0, sh}
                                         : {1'b0, ma, 3'b000} - {1'b0, sh};
            end else begin
              ed = {1'b0, b_i[62:52]} - {1'b0, a_i[62:52]};
              sh = (ed > 12'd55) ? {55'd0, 1'b1} : {ma, 3'b000} >> ed;
              if (ed > 12'd2 && ed <= 12'd55) begin
                sh[0] = sh[0] | (({ma, 3'b000} & ((56'd1 << ed) - 56'd1)) != 56'd0);
              end
              sgn_d = b_i[63];
              exp_d = eb;
              sum = (a_i[63] == b_i[63]) ? {1'b0, mb, 3'b000} + {1'b0, sh}
                                         : {1'b0, mb, 3'b000} - {1'b0, sh};
            end
            if (sum == 57'd0) begin
              op_d = w3j_pkg::OP_PASS; res_d = 64'd0;
            end
            acc_d = {52'd0, sum};
          end
        end
        w3j_pkg::OP_SQRT: begin
          sgn_d = 1'b0;
          if (a_i[52]) begin
            acc_d = {1'b0, ma, 55'd0};
            exp_d = (ea - 13'sd1075) >>> 1;
          end else begin
            acc_d = {ma, 56'd0};
            exp_d = (ea - 13'sd1076) >>> 1;
          end
          if (a_i[62:52] == 11'd0) begin
            op_d = w3j_pkg::OP_PASS; res_d = a_i;
          end
        end
        default: begin
          op_d = w3j_pkg::OP_PASS; res_d = a_i;
        end
      endcase
    end else if (busy_q) begin
      cnt_d = cnt_q + 7'd1;
      unique case (op_q)
        w3j_pkg::OP_MUL: begin
          // shift-add, one multiplier bit per cycle
          if (cnt_q < 7'd53) begin
            if (acc_q[0]) rem_d = rem_q + {3'd0, mb_q, 53'd0};
            rem_d = rem_d >> 1;
            acc_d = acc_q >> 1;
            rem_d[108] = 1'b0;
          end else begin
            // product is in rem_q[105:0] as 53+53 bits
            if (rem_q[105]) begin
              r = {1'b0, rem_q[105:52]};
              stick = rem_q[51:0] != 52'd0;
              exp_d = exp_q + 13'sd1;
            end else begin
              r = {1'b0, rem_q[104:51]};
              stick = rem_q[50:0] != 51'd0;
            end
            lsb = r[1]; rb = r[0];
            r = {1'b0, r[54:1]} + {54'd0, rb & (stick | lsb)};
            if (r[53]) begin
              r = r >> 1; exp_d = exp_d + 13'sd1;
            end
            res_d = {sgn_q, exp_d[10:0], r[51:0]};
            busy_d = 1'b0; done_d = 1'b1;
          end
        end
        w3j_pkg::OP_DIV: begin
          if (cnt_q < 7'd55) begin
            trial = rem_q - {56'd0, mb_q};
            if (!trial[108]) begin
              quo_d = {quo_q[54:0], 1'b1}; rem_d = trial << 1;
            end else begin
              quo_d = {quo_q[54:0], 1'b0}; rem_d = rem_q << 1;
            end
          end else begin
            stick = rem_q != 109'd0;
            if (quo_q[54]) begin
              r = {1'b0, quo_q[54:1]};
              stick = stick | quo_q[0];
            end else begin
              r = {1'b0, quo_q[53:0]};
              exp_d = exp_q - 13'sd1;
            end
            lsb = r[1]; rb = r[0];
            r = {1'b0, r[54:1]} + {54'd0, rb & (stick | lsb)};
            if (r[53]) begin
              r = r >> 1; exp_d = exp_d + 13'sd1;
            end
            res_d = {sgn_q, exp_d[10:0], r[51:0]};
            busy_d = 1'b0; done_d = 1'b1;
          end
        end
        w3j_pkg::OP_ADD: begin
          // normalise one bit per cycle; value is acc[56:0] with 3 guard bits
          if (acc_q[56]) begin
            acc_d = {acc_q[108:1] | {107'd0, acc_q[0]}, 1'b0} >> 1;
            acc_d[0] = acc_q[1] | acc_q[0];
            acc_d[56] = 1'b0;
            exp_d = exp_q + 13'sd1;
          end else if (!acc_q[55]) begin
            acc_d = acc_q << 1;
            exp_d = exp_q - 13'sd1;
          end else begin
            r = {1'b0, acc_q[55:2]};
            stick = acc_q[1] | acc_q[0];
            lsb = r[1]; rb = r[0];
            r = {1'b0, r[54:1]} + {54'd0, rb & (stick | lsb)};
            if (r[53]) begin
              r = r >> 1; exp_d = exp_q + 13'sd1;
            end
            res_d = {sgn_q, exp_d[10:0], r[51:0]};
            busy_d = 1'b0; done_d = 1'b1;
          end
        end
        w3j_pkg::OP_SQRT: begin
          if (cnt_q < 7'd54) begin
            trial = {rem_q[106:0], acc_q[108:107]} - {51'd0, quo_q, 2'b01};
            if (!trial[108]) begin
              rem_d = trial; quo_d = {quo_q[54:0], 1'b1};
            end else begin
              rem_d = {rem_q[106:0], acc_q[108:107]}; quo_d = {quo_q[54:0], 1'b0};
            end
            acc_d = acc_q << 2;
          end else begin
            r = {1'b0, quo_q[54:1]};
            rnd_d = quo_q[0] & ((rem_q != 109'd0) | r[0]);
            r = r + {54'd0, rnd_d};
            exp_d = exp_q + 13'sd1049;
            if (r[53]) begin
              r = r >> 1; exp_d = exp_d + 13'sd1;
            end
            res_d = {1'b0, exp_d[10:0], r[51:0]};
            busy_d = 1'b0; done_d = 1'b1;
          end
        end
        default: begin
          busy_d = 1'b0; done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= 7'd0; op_q <= w3j_pkg::OP_PASS;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q <= sgn_d; exp_q <= exp_d; acc_q <= acc_d; rem_q <= rem_d;
    quo_q <= quo_d; mb_q <= mb_d; res_q <= res_d; rnd_q <= rnd_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
